// ----- sv/cfsp_pkg.sv -----
// Shared types, constants and helpers for the cube face to sphere projection.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cfsp_pkg;

  // Q2.14 fixed point
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE >> 1;

  // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for x up to ONE
  localparam int RECIP3       = 21846;
  localparam int RECIP3_SHIFT = 16;

  // Unit latencies in register stages
  localparam int FRONT_LAT  = 5;
  localparam int SQRT_LAT   = 16;
  localparam int DIV_LAT    = 15;
  localparam int PIPE_DEPTH = FRONT_LAT + SQRT_LAT + 3 + SQRT_LAT + 1 + DIV_LAT + 1;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  typedef struct packed {
    logic [2:0]         face_number;
    logic signed [15:0] u_coord;
    logic signed [15:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sphere_x;
    logic signed [15:0] sphere_y;
    logic signed [15:0] sphere_z;
  } out_item_t;

  // magnitude of a 16-bit signed value
  function automatic logic [15:0] abs16(input logic signed [15:0] val);
    logic [15:0] res;
    res = val[15] ? 16'(-val) : 16'(val);
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cube_face_to_sphere_projection.sv -----
// Cube face to unit sphere projection, top level.
// Instantiates cfsp_front, cfsp_isqrt, cfsp_div; depends on cfsp_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries a face number and
//   Q2.14 face coordinates; output channel out_valid_o / out_stall_i /
//   out_item_o carries the Q2.14 unit sphere point. A transaction completes
//   on a clock edge with valid high and stall low.
//   cfg_we_i writes cfg_wdata_i into the projection mode (0 normalise,
//   1 spherify then normalise); write it only while the block is empty.
//   Input to output is PIPE_DEPTH register stages. One transaction per cycle
//   is sustained unless the output stalls; the depth is set by two chained 16-stage
//   square root pipelines and the 15-stage divider, one result bit per stage.
//   The whole pipeline advances as one: while the output holds a result and
//   out_stall_i is high, every stage holds and in_stall_o is raised.
//   Reset clears all valid bits and sets the mode to 1.
`default_nettype none

module cube_face_to_sphere_projection import cfsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic                  mode_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  adv;

  logic signed [15:0] c_f [3];
  logic [15:0]        p_f [3];
  logic [15:0]        r_s [3];
  logic signed [15:0] cd_q [SQRT_LAT][3];

  logic [15:0] sm_q  [3];
  logic        sn_q  [3];
  logic [31:0] ms_q  [3];
  logic [15:0] sm2_q [3];
  logic        sn2_q [3];
  logic [31:0] len2_q;
  logic [15:0] sm3_q [3];
  logic        sn3_q [3];

  logic [15:0] len_s;
  logic [15:0] smd_q [SQRT_LAT][3];
  logic        snd_q [SQRT_LAT][3];
  logic        zd_q  [SQRT_LAT];

  logic [31:0] num_q [3];
  logic [15:0] den_q;
  logic        sn4_q [3];
  logic        z4_q;

  logic [14:0] quo_s [3];
  logic        sne_q [DIV_LAT][3];
  logic        ze_q  [DIV_LAT];

  out_item_t   out_q;

  // global advance: held only while a result waits at a stalled output
  assign adv         = !(vld_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign out_item_o  = out_q;

  // mode register and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (adv) vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  cfsp_front u_front (
    .clk_i  (clk_i),
    .en_i   (adv),
    .item_i (in_item_i),
    .c_o    (c_f),
    .p_o    (p_f)
  );

  // per-component square root of the polynomial, root in Q.14
  for (genvar i = 0; i < 3; i++) begin : g_root
    cfsp_isqrt u_isqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (32'(p_f[i]) << FRAC_BITS),
      .root_o (r_s[i])
    );
  end

  // scale, square, sum
  always_ff @(posedge clk_i) begin
    logic [31:0] prod;
    if (adv) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        for (int i = 0; i < 3; i++) begin
          cd_q[k][i] <= (k == 0) ? c_f[i] : cd_q[k-1][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        prod = 32'(abs16(cd_q[SQRT_LAT-1][i])) * 32'(r_s[i]) + 32'(HALF);
        sm_q[i]  <= mode_q ? 16'(prod >> FRAC_BITS) : abs16(cd_q[SQRT_LAT-1][i]);
        sn_q[i]  <= cd_q[SQRT_LAT-1][i][15];
        ms_q[i]  <= 32'(sm_q[i]) * 32'(sm_q[i]);
        sm2_q[i] <= sm_q[i];
        sn2_q[i] <= sn_q[i];
        sm3_q[i] <= sm2_q[i];
        sn3_q[i] <= sn2_q[i];
      end
      len2_q <= ms_q[0] + ms_q[1] + ms_q[2];
    end
  end

  // vector length
  cfsp_isqrt u_len (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (len2_q),
    .root_o (len_s)
  );

  // side data alongside the length root, then the rounded dividends
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        for (int i = 0; i < 3; i++) begin
          smd_q[k][i] <= (k == 0) ? sm3_q[i] : smd_q[k-1][i];
          snd_q[k][i] <= (k == 0) ? sn3_q[i] : snd_q[k-1][i];
        end
        zd_q[k] <= (k == 0) ? (len2_q == '0) : zd_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= (32'(smd_q[SQRT_LAT-1][i]) << FRAC_BITS) + 32'(len_s >> 1);
        sn4_q[i] <= snd_q[SQRT_LAT-1][i];
      end
      den_q <= len_s;
      z4_q  <= zd_q[SQRT_LAT-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    cfsp_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[i]),
      .den_i (den_q),
      .quo_o (quo_s[i])
    );
  end

  // signs and zero flag alongside the divider, then the output register
  always_ff @(posedge clk_i) begin
    logic signed [15:0] val [3];
    if (adv) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        for (int i = 0; i < 3; i++) begin
          sne_q[k][i] <= (k == 0) ? sn4_q[i] : sne_q[k-1][i];
        end
        ze_q[k] <= (k == 0) ? z4_q : ze_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        val[i] = sne_q[DIV_LAT-1][i] ? -16'(quo_s[i]) : 16'(quo_s[i]);
      end
      if (ze_q[DIV_LAT-1]) begin
        out_q.sphere_x <= '0;
        out_q.sphere_y <= '0;
        out_q.sphere_z <= 16'(ONE);
      end else begin
        out_q.sphere_x <= val[0];
        out_q.sphere_y <= val[1];
        out_q.sphere_z <= val[2];
      end
    end
  end

  // results lie on the unit sphere: within one on every axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.sphere_x <= 16'sd16384 && out_item_o.sphere_x >= -16'sd16384
                  && out_item_o.sphere_y <= 16'sd16384 && out_item_o.sphere_y >= -16'sd16384
                  && out_item_o.sphere_z <= 16'sd16384 && out_item_o.sphere_z >= -16'sd16384))
    else $error("sphere point component beyond one");

  // a result is never the zero vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.sphere_x == '0 && out_item_o.sphere_y == '0
                   && out_item_o.sphere_z == '0))
    else $error("sphere point is the zero vector");

  // a stalled result stays valid on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && in_stall_o == out_stall_i))
    else $error("pipeline advanced past a stalled result");

endmodule

`default_nettype wire

// ----- sv/cfsp_front.sv -----
// Front end: coordinate clamp, face select, squares and spherify polynomial.
// Five register stages; depends on cfsp_pkg.
`default_nettype none

module cfsp_front import cfsp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire in_item_t           item_i,
  output logic signed [15:0]      c_o [3],
  output logic        [15:0]      p_o [3]
);

  logic signed [15:0] c_d  [3];
  logic signed [15:0] c1_q [3];
  logic signed [15:0] c2_q [3];
  logic signed [15:0] c3_q [3];
  logic signed [15:0] c4_q [3];
  logic signed [15:0] c5_q [3];
  logic [14:0]        q2_q [3];
  logic [29:0]        prod3_q [3];
  logic [15:0]        neg3_q  [3];
  logic [31:0]        t4_q    [3];
  logic [15:0]        neg4_q  [3];
  logic [15:0]        p5_q    [3];

  // clamp and select the cube point
  always_comb begin
    logic signed [15:0] uc;
    logic signed [15:0] vc;
    logic signed [15:0] one_s;
    one_s = 16'(ONE);
    uc = item_i.u_coord;
    vc = item_i.v_coord;
    if (uc > one_s) uc = one_s;
    else if (uc < -one_s) uc = -one_s;
    if (vc > one_s) vc = one_s;
    else if (vc < -one_s) vc = -one_s;
    unique case (face_e'(item_i.face_number))
      FACE_PX: begin c_d[0] = one_s;  c_d[1] = vc;     c_d[2] = -uc;    end
      FACE_NX: begin c_d[0] = -one_s; c_d[1] = vc;     c_d[2] = uc;     end
      FACE_PY: begin c_d[0] = uc;     c_d[1] = one_s;  c_d[2] = vc;     end
      FACE_NY: begin c_d[0] = uc;     c_d[1] = -one_s; c_d[2] = -vc;    end
      FACE_NZ: begin c_d[0] = -uc;    c_d[1] = vc;     c_d[2] = -one_s; end
      default: begin c_d[0] = uc;     c_d[1] = vc;     c_d[2] = one_s;  end
    endcase
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        c1_q[i] <= c_d[i];
        c2_q[i] <= c1_q[i];
        c3_q[i] <= c2_q[i];
        c4_q[i] <= c3_q[i];
        c5_q[i] <= c4_q[i];
        // squares, floor(c*c / ONE)
        q2_q[i] <= 15'((32'(abs16(c1_q[i])) * 32'(abs16(c1_q[i]))) >> FRAC_BITS);
      end
      // cross products and halves of the other two squares
      prod3_q[0] <= 30'(q2_q[1]) * 30'(q2_q[2]);
      prod3_q[1] <= 30'(q2_q[0]) * 30'(q2_q[2]);
      prod3_q[2] <= 30'(q2_q[0]) * 30'(q2_q[1]);
      neg3_q[0]  <= 16'(q2_q[1] >> 1) + 16'(q2_q[2] >> 1);
      neg3_q[1]  <= 16'(q2_q[0] >> 1) + 16'(q2_q[2] >> 1);
      neg3_q[2]  <= 16'(q2_q[0] >> 1) + 16'(q2_q[1] >> 1);
      for (int i = 0; i < 3; i++) begin
        // divide by 3*ONE: shift then reciprocal multiply
        t4_q[i]   <= 32'(prod3_q[i] >> FRAC_BITS) * 32'(RECIP3);
        neg4_q[i] <= neg3_q[i];
      end
    end
  end

  // polynomial, clamped at zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (16'(ONE) + 16'(t4_q[i] >> RECIP3_SHIFT) > neg4_q[i]) begin
          p5_q[i] <= 16'(ONE) + 16'(t4_q[i] >> RECIP3_SHIFT) - neg4_q[i];
        end else begin
          p5_q[i] <= '0;
        end
      end
    end
  end

  assign c_o = c5_q;
  assign p_o = p5_q;

endmodule

`default_nettype wire

// ----- sv/cfsp_isqrt.sv -----
// Pipelined integer square root, 32-bit radicand, 16-bit root, one bit per stage.
// Depends on cfsp_pkg for the stage count.
`default_nettype none

module cfsp_isqrt import cfsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] rad_i,
  output logic      [15:0] root_o
);

  logic [31:0] rad_q  [SQRT_LAT];
  logic [17:0] rem_q  [SQRT_LAT];
  logic [15:0] root_q [SQRT_LAT];

  always_ff @(posedge clk_i) begin
    logic [31:0] rad_p;
    logic [17:0] rem_p;
    logic [15:0] root_p;
    logic [19:0] cur;
    logic [19:0] trial;
    if (en_i) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        if (k == 0) begin
          rad_p  = rad_i;
          rem_p  = '0;
          root_p = '0;
        end else begin
          rad_p  = rad_q[k-1];
          rem_p  = rem_q[k-1];
          root_p = root_q[k-1];
        end
        // bring down two radicand bits, try root bit one
        cur   = {rem_p, rad_p[31:30]};
        trial = {2'b00, root_p, 2'b01};
        rad_q[k] <= rad_p << 2;
        if (cur >= trial) begin
          rem_q[k]  <= 18'(cur - trial);
          root_q[k] <= {root_p[14:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[17:0];
          root_q[k] <= {root_p[14:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

`default_nettype wire

// ----- sv/cfsp_div.sv -----
// Pipelined restoring divider: 32-bit dividend below den<<15, 15-bit quotient.
// One quotient bit per stage; depends on cfsp_pkg.
`default_nettype none

module cfsp_div import cfsp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] num_i,
  input  wire logic [15:0] den_i,
  output logic      [14:0] quo_o
);

  logic [31:0] rem_q [DIV_LAT];
  logic [15:0] den_q [DIV_LAT];
  logic [14:0] quo_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    logic [31:0] rem_p;
    logic [15:0] den_p;
    logic [14:0] quo_p;
    logic [31:0] sub;
    if (en_i) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        if (k == 0) begin
          rem_p = num_i;
          den_p = den_i;
          quo_p = '0;
        end else begin
          rem_p = rem_q[k-1];
          den_p = den_q[k-1];
          quo_p = quo_q[k-1];
        end
        // quotient bit DIV_LAT-1-k
        sub = 32'(den_p) << (DIV_LAT - 1 - k);
        den_q[k] <= den_p;
        if (rem_p >= sub) begin
          rem_q[k] <= rem_p - sub;
          quo_q[k] <= {quo_p[13:0], 1'b1};
        end else begin
          rem_q[k] <= rem_p;
          quo_q[k] <= {quo_p[13:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule

`default_nettype wire

// ----- verif/cfsp_checker.sv -----
// Checker for the cube face to sphere projection: watches both channels,
// predicts each result and compares it with what the block returns.
// Depends on cfsp_pkg.
`timescale 1ns / 100ps

module cfsp_checker import cfsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        results_seen_o
);

  logic      spherify_mode;
  out_item_t expected_points[$];

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [15:0] sat16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // scale one component by the root of the clamped polynomial
  function automatic longint scale_component(input longint c, input longint unsigned qa,
                                             input longint unsigned qb);
    longint unsigned pos, neg, p, r, m;
    pos = ONE + (qa * qb) / (3 * ONE);
    neg = (qa >> 1) + (qb >> 1);
    p = pos > neg ? pos - neg : 0;
    r = int_sqrt(p << FRAC_BITS);
    m = (mag(c) * r + HALF) >> FRAC_BITS;
    return c < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic out_item_t project_point(input in_item_t it, input logic sph);
    longint u, v, c[3], s[3];
    longint unsigned q[3], len2, len, r;
    out_item_t res;
    u = it.u_coord;
    v = it.v_coord;
    if (u > ONE) u = ONE;
    if (u < -ONE) u = -ONE;
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    case (it.face_number)
      FACE_PX: begin c[0] = ONE;  c[1] = v;    c[2] = -u;   end
      FACE_NX: begin c[0] = -ONE; c[1] = v;    c[2] = u;    end
      FACE_PY: begin c[0] = u;    c[1] = ONE;  c[2] = v;    end
      FACE_NY: begin c[0] = u;    c[1] = -ONE; c[2] = -v;   end
      FACE_NZ: begin c[0] = -u;   c[1] = v;    c[2] = -ONE; end
      default: begin c[0] = u;    c[1] = v;    c[2] = ONE;  end
    endcase
    if (sph) begin
      for (int i = 0; i < 3; i++) q[i] = (mag(c[i]) * mag(c[i])) >> FRAC_BITS;
      s[0] = scale_component(c[0], q[1], q[2]);
      s[1] = scale_component(c[1], q[0], q[2]);
      s[2] = scale_component(c[2], q[0], q[1]);
    end else begin
      s = c;
    end
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += mag(s[i]) * mag(s[i]);
    // degenerate length falls back to +Z
    if (len2 == 0) begin
      res.sphere_x = '0;
      res.sphere_y = '0;
      res.sphere_z = sat16(ONE);
      return res;
    end
    len = int_sqrt(len2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      r = (mag(s[i]) * ONE + (len >> 1)) / len;
      c[i] = s[i] < 0 ? -longint'(r) : longint'(r);
    end
    res.sphere_x = sat16(c[0]);
    res.sphere_y = sat16(c[1]);
    res.sphere_z = sat16(c[2]);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch %s got %0d expected %0d", $time, what,
             $signed(got), $signed(want));
    fail_count_o++;
  endtask

  assign pending_o = expected_points.size();

  // register tracking, prediction at input, comparison at output
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      spherify_mode <= 1'b1;
      expected_points.delete();
      fail_count_o = 0;
      results_seen_o = 0;
    end else begin
      if (cfg_we_i) spherify_mode <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        expected_points.insert(expected_points.size(),
                               project_point(in_item_i, spherify_mode));
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result transaction", $time);
          fail_count_o++;
        end else begin
          want = expected_points.pop_front();
          if (out_item_i.sphere_x !== want.sphere_x)
            report_mismatch("sphere_x", out_item_i.sphere_x, want.sphere_x);
          if (out_item_i.sphere_y !== want.sphere_y)
            report_mismatch("sphere_y", out_item_i.sphere_y, want.sphere_y);
          if (out_item_i.sphere_z !== want.sphere_z)
            report_mismatch("sphere_z", out_item_i.sphere_z, want.sphere_z);
        end
      end
    end
  end

endmodule

// ----- verif/tb_cube_face_to_sphere_projection.sv -----
// Testbench top for cube_face_to_sphere_projection: drives stimulus, stalls
// the output, gives the verdict. Depends on it, cfsp_pkg and cfsp_checker.
`timescale 1ns / 100ps

module tb_cube_face_to_sphere_projection;
  import cfsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = PIPE_DEPTH + 10;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i = 1'b0;
  in_item_t  in_item_i = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o, out_valid_o;
  out_item_t out_item_o;
  int        fail_count, pending, results_seen;
  int        idle_cycles = 0;
  bit        long_hold = 1'b0;
  bit        stim_done = 1'b0;
  int        items_sent = 0;

  always #10 clk_i = ~clk_i;

  cube_face_to_sphere_projection u_top (.*);

  cfsp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // offer one transaction and hold it until taken
  task automatic send_point(input logic [2:0] face, input logic [15:0] u,
                            input logic [15:0] v);
    in_valid_i <= 1'b1;
    in_item_i  <= '{face_number: face, u_coord: u, v_coord: v};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic idle_input(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'($urandom());
    if (k == 1) return 16'(ONE);
    if (k == 2) return 16'(-ONE);
    return 16'($urandom_range(0, 2 * ONE) - ONE);
  endfunction

  // edge values on every face number, plus a few other points
  task automatic directed_set();
    logic [15:0] corners[5];
    corners = '{16'(-ONE), 16'(ONE), 16'h0, 16'h7fff, 16'h8000};
    for (int f = 0; f < 8; f++) begin
      send_point(3'(f), corners[f % 5], corners[(f + 2) % 5]);
      if (f < 2) send_point(3'(f), 16'(ONE), 16'(ONE));
    end
    send_point(FACE_PZ, 16'h5555, 16'haaaa);
    send_point(FACE_NY, 16'(-ONE), 16'(-ONE));
  endtask

  task automatic random_set(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n > 0; i++, n--)
        send_point(3'($urandom()), rand_coord(), rand_coord());
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (long_hold) out_stall_i <= 1'b1;
    else if (stim_done) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0) && (items_sent % 400 > 100);
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset mode is spherify
    directed_set();
    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_mode(1'b0);
    directed_set();
    random_set(400);
    drain_pipe();
    write_mode(1'b1);
    // long receiver hold while the sender keeps offering
    fork
      begin
        long_hold = 1'b1;
        repeat (200) @(posedge clk_i);
        long_hold = 1'b0;
      end
      random_set(300);
    join
    random_set(500);
    drain_pipe();
    write_mode(1'b0);
    random_set(300);
    drain_pipe();
    write_mode(1'b1);
    random_set(350);
    drain_pipe();
    stim_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d points over all faces in both projection modes, %0d results",
             items_sent, results_seen);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
